FILE: rtl/mhrm_pkg.sv
// ----------------------------------------------------------------------------
// mhrm_pkg
// Shared types and constants of the min-heap remove-matching block: beat
// layouts, operation and status codes, and the compare unit's result.
// ----------------------------------------------------------------------------
package mhrm_pkg;

  // Field widths of one input beat and one result beat
  localparam int unsigned OP_W   = 2;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned STAT_W = 2;

  // Packed tdata widths, rounded up to whole bytes
  localparam int unsigned IN_RAW_W  = OP_W + VAL_W + IDX_W;
  localparam int unsigned IN_W      = ((IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_W = VAL_W + CNT_W + CNT_W + STAT_W;
  localparam int unsigned OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  // Status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  // Result of the shared compare unit
  typedef struct packed {
    logic gt;  // a greater than b, signed
    logic eq;  // a equal to b
  } cmp_res_t;

endpackage

FILE: rtl/mhrm_ram.sv
// ----------------------------------------------------------------------------
// mhrm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mhrm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mhrm_cmp.sv
// ----------------------------------------------------------------------------
// mhrm_cmp
// Shared compare unit: signed greater-than and equality of two entries.
// ----------------------------------------------------------------------------
module mhrm_cmp (
  input  logic [mhrm_pkg::VAL_W-1:0] a_i,
  input  logic [mhrm_pkg::VAL_W-1:0] b_i,
  output mhrm_pkg::cmp_res_t         res_o
);
  import mhrm_pkg::*;

  // Compare as two's complement values
  always_comb begin
    res_o.gt = $signed(a_i) > $signed(b_i);
    res_o.eq = (a_i == b_i);
  end

endmodule

FILE: rtl/min_heap_remove_matching_core.sv
// ----------------------------------------------------------------------------
// min_heap_remove_matching_core
// Array-stored binary min-heap with append, remove-all-matching with rebuild,
// indexed read and clear, run by a small sequencer around one RAM and one
// shared compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   Each beat on the s_axis side carries one operation; every operation gives
//   exactly one result beat on the m_axis side. The input side is ready only
//   while the sequencer is idle and the result register is empty or being
//   emptied in the same cycle.
//   Append, clear and an out-of-range read: result valid in the cycle after
//   the input beat; a new beat can be taken every cycle while the receiver
//   takes each result. In-range read: the RAM read is registered, then the
//   S_RD state moves the read data into the result register. Remove: the
//   compaction pass reads each held entry and drops a match or moves the
//   entry down; the rebuild then sifts down each of the n/2 parents, per
//   level fetching the left and any right child, comparing, and moving the
//   smaller child up until the entry settles above them or at a leaf.
//   The single RAM port pair and the one compare unit set the pace of this.
//   Reset empties the heap and drops any pending result; the RAM contents are
//   not cleared. When the receiver stalls, the result beat is held and no new
//   input beat is taken.
// ----------------------------------------------------------------------------
module min_heap_remove_matching_core #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [1:0] op, [33:2] value, [41:34] index, [47:42] zero
  input  logic [mhrm_pkg::IN_W-1:0] s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // [31:0] read_value, [40:32] deleted_count, [49:41] heap_size,
  // [51:50] status, [55:52] zero
  output logic [mhrm_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import mhrm_pkg::*;

  localparam int unsigned NW  = $clog2(CAPACITY + 1);
  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned CW  = NW + 1;
  localparam int unsigned IXW = (NW > IDX_W) ? NW : IDX_W;
  localparam logic [NW-1:0] CapN = NW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CP_RD,
    S_CP_CHK,
    S_HP,
    S_SD_PAR,
    S_SD_CH,
    S_SD_L,
    S_SD_R,
    S_SD_CMP
  } state_e;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] deleted_count;
    logic [CNT_W-1:0] heap_size;
    status_e          status;
  } res_t;

  state_e           state_q, state_d;
  logic [NW-1:0]    count_q, count_d;
  logic [NW-1:0]    r_q, r_d;
  logic [NW-1:0]    w_q, w_d;
  logic [NW-1:0]    del_q, del_d;
  logic [NW-1:0]    p_q, p_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    bpos_q, bpos_d;
  logic [VAL_W-1:0] opnd_q, opnd_d;
  logic [VAL_W-1:0] best_q, best_d;
  logic             m_valid_q, m_valid_d;
  res_t             res_q, res_d;

  logic             accept;
  op_e              in_op;
  logic [VAL_W-1:0] in_value;
  logic [IDX_W-1:0] in_index;
  logic [IXW-1:0]   idx_ext;
  logic [NW-1:0]    p_m1;
  logic [CW-1:0]    child_w;
  logic [CW-1:0]    child_p1;
  logic [CW-1:0]    cnt_ext;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  logic [VAL_W-1:0] cmp_a;
  logic [VAL_W-1:0] cmp_b;
  cmp_res_t         cmp_res;

  // Unpack the input beat
  assign in_op    = op_e'(s_axis_tdata_i[OP_W-1:0]);
  assign in_value = s_axis_tdata_i[OP_W +: VAL_W];
  assign in_index = s_axis_tdata_i[OP_W+VAL_W +: IDX_W];
  assign idx_ext  = IXW'(in_index);

  // Handshake
  assign s_axis_tready_o = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Tree index arithmetic
  assign p_m1     = p_q - NW'(1);
  assign child_w  = CW'({pos_q, 1'b1});
  assign child_p1 = child_w + CW'(1);
  assign cnt_ext  = CW'(count_q);

  // Route operands to the shared compare unit
  always_comb begin
    case (state_q)
      S_CP_CHK: begin
        cmp_a = ram_rdata;
        cmp_b = opnd_q;
      end
      S_SD_R: begin
        cmp_a = best_q;
        cmp_b = ram_rdata;
      end
      default: begin
        cmp_a = opnd_q;
        cmp_b = best_q;
      end
    endcase
  end

  mhrm_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  mhrm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    r_d       = r_q;
    w_d       = w_q;
    del_d     = del_q;
    p_d       = p_q;
    pos_d     = pos_q;
    bpos_d    = bpos_q;
    opnd_d    = opnd_q;
    best_d    = best_q;
    res_d     = res_q;
    m_valid_d = m_valid_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = opnd_q;
    ram_re    = 1'b0;
    ram_raddr = pos_q;

    // Drop the result once taken
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.read_value    = '0;
          res_d.deleted_count = '0;
          res_d.status        = STAT_OK;
          res_d.heap_size     = CNT_W'(count_q);
          case (in_op)
            OP_APPEND: begin
              m_valid_d = 1'b1;
              if (count_q < CapN) begin
                ram_we          = 1'b1;
                ram_waddr       = count_q[AW-1:0];
                ram_wdata       = in_value;
                count_d         = count_q + NW'(1);
                res_d.heap_size = CNT_W'(count_d);
              end else begin
                res_d.status = STAT_FULL;
              end
            end
            OP_REMOVE: begin
              opnd_d  = in_value;
              r_d     = '0;
              w_d     = '0;
              del_d   = '0;
              state_d = S_CP_RD;
            end
            OP_READ: begin
              if (idx_ext < IXW'(count_q)) begin
                ram_re    = 1'b1;
                ram_raddr = idx_ext[AW-1:0];
                state_d   = S_RD;
              end else begin
                res_d.status = STAT_RANGE;
                m_valid_d    = 1'b1;
              end
            end
            OP_CLEAR: begin
              count_d         = '0;
              res_d.heap_size = '0;
              m_valid_d       = 1'b1;
            end
            default: ;
          endcase
        end
      end

      // Present the read data
      S_RD: begin
        res_d.read_value = ram_rdata;
        m_valid_d        = 1'b1;
        state_d          = S_IDLE;
      end

      // Compaction: fetch the next entry or start the rebuild
      S_CP_RD: begin
        if (r_q == count_q) begin
          count_d = w_q;
          p_d     = w_q >> 1;
          state_d = S_HP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = r_q[AW-1:0];
          state_d   = S_CP_CHK;
        end
      end

      // Compaction: drop a match, otherwise move the entry down to w
      S_CP_CHK: begin
        if (cmp_res.eq) begin
          del_d = del_q + NW'(1);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = w_q[AW-1:0];
          ram_wdata = ram_rdata;
          w_d       = w_q + NW'(1);
        end
        r_d     = r_q + NW'(1);
        state_d = S_CP_RD;
      end

      // Rebuild: next parent downwards, or finish
      S_HP: begin
        if (p_q == '0) begin
          res_d.deleted_count = CNT_W'(del_q);
          res_d.heap_size     = CNT_W'(count_q);
          m_valid_d           = 1'b1;
          state_d             = S_IDLE;
        end else begin
          p_d       = p_m1;
          pos_d     = p_m1[AW-1:0];
          ram_re    = 1'b1;
          ram_raddr = p_m1[AW-1:0];
          state_d   = S_SD_PAR;
        end
      end

      // Sift-down: hold the moving entry
      S_SD_PAR: begin
        opnd_d  = ram_rdata;
        state_d = S_SD_CH;
      end

      // Sift-down: settle at a leaf or fetch the left child
      S_SD_CH: begin
        if (child_w >= cnt_ext) begin
          ram_we  = 1'b1;
          state_d = S_HP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = child_w[AW-1:0];
          state_d   = S_SD_L;
        end
      end

      // Sift-down: take the left child, fetch the right one if present
      S_SD_L: begin
        best_d = ram_rdata;
        bpos_d = child_w[AW-1:0];
        if (child_p1 < cnt_ext) begin
          ram_re    = 1'b1;
          ram_raddr = child_p1[AW-1:0];
          state_d   = S_SD_R;
        end else begin
          state_d = S_SD_CMP;
        end
      end

      // Sift-down: right child wins only when strictly smaller
      S_SD_R: begin
        if (cmp_res.gt) begin
          best_d = ram_rdata;
          bpos_d = child_p1[AW-1:0];
        end
        state_d = S_SD_CMP;
      end

      // Sift-down: move the smaller child up, or settle here
      S_SD_CMP: begin
        ram_we = 1'b1;
        if (cmp_res.gt) begin
          ram_wdata = best_q;
          pos_d     = bpos_q;
          state_d   = S_SD_CH;
        end else begin
          state_d = S_HP;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      r_q       <= '0;
      w_q       <= '0;
      del_q     <= '0;
      p_q       <= '0;
      pos_q     <= '0;
      bpos_q    <= '0;
      opnd_q    <= '0;
      best_q    <= '0;
      m_valid_q <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      r_q       <= r_d;
      w_q       <= w_d;
      del_q     <= del_d;
      p_q       <= p_d;
      pos_q     <= pos_d;
      bpos_q    <= bpos_d;
      opnd_q    <= opnd_d;
      best_q    <= best_d;
      m_valid_q <= m_valid_d;
      res_q     <= res_d;
    end
  end

  // Pack the result beat
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_W'({res_q.status, res_q.heap_size,
                                   res_q.deleted_count, res_q.read_value});

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapN)
    else $error("entry count above capacity");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_op == OP_APPEND) && (count_q < CapN))
      |=> (count_q == $past(count_q) + NW'(1)))
    else $error("append did not grow the heap by one");

  a_size_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (res_q.heap_size == CNT_W'(count_q)))
    else $error("reported heap size differs from entry count");

  a_sift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SD_CH) |-> (NW'(pos_q) < count_q))
    else $error("sift-down position beyond held entries");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the min-heap remove-matching core. A mirror of the
// heap store predicts every result beat; a checker compares each one, field
// by field, against the oldest prediction. Directed cases come first, then a
// full-store pass, a long receiver hold-off, and random operation sequences
// with random gaps and stalls on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
  import mhrm_pkg::*;

  localparam int unsigned CAPACITY    = 256;
  localparam int unsigned ITEM_TARGET = 1650;
  localparam int unsigned POOL_N      = 6;
  localparam int unsigned HOLD_CYCLES = 400;
  // Worst remove at full size, plus the longest gap and stall per beat
  localparam longint unsigned REMOVE_WORST = 2 * CAPACITY + 2 + (CAPACITY / 2) * (4 + 4 * 8);
  localparam longint unsigned CYCLE_LIMIT  = 4 * 2000 * (REMOVE_WORST + 130) + HOLD_CYCLES;

  typedef struct {
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] deleted_count;
    logic [CNT_W-1:0] heap_size;
    status_e          status;
  } heap_resp_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  // Mirror of the heap store and its fill level
  logic [VAL_W-1:0]  mirror_store [CAPACITY];
  int unsigned       mirror_count;
  heap_resp_t        pending_resp_q [$];
  logic [VAL_W-1:0]  value_pool [POOL_N];

  int unsigned       mismatch_count;
  int unsigned       beats_sent;
  int unsigned       op_beats [4];
  int unsigned       full_refusals, range_reads, removes_hit, peak_size;
  longint unsigned   cycle_count;

  // Idling controls for the sender and the receiver process
  bit                tx_gaps_on;
  bit                rx_stalls_on;
  int unsigned       rx_hold_req;
  int unsigned       rx_hold_left;
  int unsigned       rx_stall_left;

  min_heap_remove_matching_core #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short lengths, now and then a long one
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sift one entry of the mirror down; the left child wins a tie
  function automatic void mirror_sift_down(input int unsigned start, input int unsigned n);
    int unsigned pos;
    int unsigned child;
    logic [VAL_W-1:0] tmp;
    bit done;
    pos  = start;
    done = 1'b0;
    while (!done) begin
      child = 2 * pos + 1;
      if (child >= n) begin
        done = 1'b1;
      end else begin
        if (child + 1 < n && $signed(mirror_store[child]) > $signed(mirror_store[child + 1]))
          child++;
        if (!($signed(mirror_store[pos]) > $signed(mirror_store[child]))) begin
          done = 1'b1;
        end else begin
          tmp                 = mirror_store[pos];
          mirror_store[pos]   = mirror_store[child];
          mirror_store[child] = tmp;
          pos                 = child;
        end
      end
    end
  endfunction

  // Apply one operation to the mirror and work out its result beat
  function automatic heap_resp_t heap_apply_op(input op_e op, input logic [VAL_W-1:0] val,
                                               input logic [IDX_W-1:0] idx);
    heap_resp_t  resp;
    int unsigned wr;
    int unsigned p;
    resp.read_value    = '0;
    resp.deleted_count = '0;
    resp.status        = STAT_OK;
    case (op)
      OP_APPEND: begin
        if (mirror_count >= CAPACITY) begin
          resp.status = STAT_FULL;
        end else begin
          mirror_store[mirror_count] = val;
          mirror_count++;
        end
      end
      OP_REMOVE: begin
        wr = 0;
        for (int unsigned rd = 0; rd < mirror_count; rd++) begin
          if (mirror_store[rd] == val) resp.deleted_count++;
          else begin
            mirror_store[wr] = mirror_store[rd];
            wr++;
          end
        end
        mirror_count = wr;
        p = mirror_count / 2;
        while (p > 0) begin
          p--;
          mirror_sift_down(p, mirror_count);
        end
      end
      OP_READ: begin
        if (idx < mirror_count) resp.read_value = mirror_store[idx];
        else resp.status = STAT_RANGE;
      end
      default: begin
        mirror_count = 0;
      end
    endcase
    resp.heap_size = mirror_count[CNT_W-1:0];
    return resp;
  endfunction

  // Offer one beat, wait for the handshake, then record its prediction
  task automatic send_beat(input op_e op, input logic [VAL_W-1:0] val,
                           input logic [IDX_W-1:0] idx);
    heap_resp_t  resp;
    int unsigned gap;
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W - IN_RAW_W){1'b0}}, idx, val, op};
    do @(posedge clk_i); while (s_tready !== 1'b1);
    resp = heap_apply_op(op, val, idx);
    pending_resp_q.insert(pending_resp_q.size(), resp);
    beats_sent++;
    op_beats[op]++;
    if (resp.status == STAT_FULL) full_refusals++;
    if (resp.status == STAT_RANGE) range_reads++;
    if (resp.deleted_count != 0) removes_hit++;
    if (mirror_count > peak_size) peak_size = mirror_count;
    // Drop valid for a while now and then
    if (tx_gaps_on && $urandom_range(0, 99) < 35) begin
      gap = pick_len();
      @(negedge clk_i);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic logic [VAL_W-1:0] pool_value();
    if ($urandom_range(0, 99) < 75) return value_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom;
  endfunction

  // Refill the value pool: extremes, small numbers and wide random words
  task automatic refresh_pool();
    int unsigned r;
    for (int unsigned i = 0; i < POOL_N; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        case ($urandom_range(0, 3))
          0: value_pool[i] = 32'h7FFF_FFFF;
          1: value_pool[i] = 32'h8000_0000;
          2: value_pool[i] = 32'h0000_0000;
          default: value_pool[i] = 32'hFFFF_FFFF;
        endcase
      end else if (r < 40) begin
        value_pool[i] = $urandom_range(0, 15) - 8;
      end else begin
        value_pool[i] = $urandom;
      end
    end
  endtask

  task automatic send_read_in_range();
    if (mirror_count == 0) send_beat(OP_READ, $urandom, IDX_W'($urandom_range(0, 255)));
    else send_beat(OP_READ, $urandom, IDX_W'($urandom_range(0, mirror_count - 1)));
  endtask

  // Receiver: long hold-off on request, else random stalls or always ready
  always begin : receiver
    @(negedge clk_i);
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (!rx_stalls_on) begin
      m_tready <= 1'b1;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 99) < 30) rx_stall_left = pick_len();
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : result_check
    heap_resp_t want;
    logic [VAL_W-1:0] got_value;
    logic [CNT_W-1:0] got_deleted;
    logic [CNT_W-1:0] got_size;
    logic [STAT_W-1:0] got_status;
    if (rst_ni && m_tvalid && m_tready) begin
      got_value   = m_tdata[31:0];
      got_deleted = m_tdata[40:32];
      got_size    = m_tdata[49:41];
      got_status  = m_tdata[51:50];
      if (pending_resp_q.size() == 0) begin
        $error("result beat with no prediction waiting");
        mismatch_count++;
      end else begin
        want = pending_resp_q.pop_front();
        if (got_value !== want.read_value) begin
          $error("read_value mismatch: expected %0d, got %0d",
                 $signed(want.read_value), $signed(got_value));
          mismatch_count++;
        end
        if (got_deleted !== want.deleted_count) begin
          $error("deleted_count mismatch: expected %0d, got %0d",
                 want.deleted_count, got_deleted);
          mismatch_count++;
        end
        if (got_size !== want.heap_size) begin
          $error("heap_size mismatch: expected %0d, got %0d", want.heap_size, got_size);
          mismatch_count++;
        end
        if (got_status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, got_status);
          mismatch_count++;
        end
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Extremes, every operation and the named corner cases
  task automatic test_directed();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    send_beat(OP_CLEAR, 32'h0, 8'd0);
    send_beat(OP_READ, 32'h0, 8'd0);
    send_beat(OP_REMOVE, 32'd5, 8'd0);
    send_beat(OP_APPEND, 32'h7FFF_FFFF, 8'hFF);
    send_beat(OP_APPEND, 32'h8000_0000, 8'd0);
    send_beat(OP_APPEND, 32'h0000_0000, 8'd0);
    send_beat(OP_APPEND, 32'hFFFF_FFFF, 8'd0);
    send_beat(OP_APPEND, 32'h0000_0000, 8'd0);
    send_beat(OP_APPEND, 32'd3, 8'd0);
    send_beat(OP_READ, 32'h0, 8'd0);
    send_beat(OP_READ, 32'h0, 8'd5);
    // Remove a duplicated value, then check the rebuilt order
    send_beat(OP_REMOVE, 32'h0, 8'd0);
    for (int unsigned i = 0; i < 4; i++) send_beat(OP_READ, 32'h0, i[IDX_W-1:0]);
    send_beat(OP_READ, 32'hFFFF_FFFF, 8'hFF);
    send_beat(OP_REMOVE, 32'd12345, 8'd0);
    // Equal children: the left one must move up
    send_beat(OP_CLEAR, 32'hFFFF_FFFF, 8'hFF);
    send_beat(OP_APPEND, 32'd9, 8'd0);
    send_beat(OP_APPEND, 32'd4, 8'd0);
    send_beat(OP_APPEND, 32'd4, 8'd0);
    send_beat(OP_REMOVE, 32'd100, 8'd0);
    send_beat(OP_READ, 32'h0, 8'd1);
    send_beat(OP_READ, 32'h0, 8'd2);
  endtask

  // Fill the store to capacity, refuse one more, remove at full size
  task automatic test_full_store();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    refresh_pool();
    send_beat(OP_CLEAR, $urandom, 8'd0);
    for (int unsigned i = 0; i < CAPACITY; i++) send_beat(OP_APPEND, pool_value(), 8'd0);
    send_beat(OP_APPEND, $urandom, 8'd0);
    send_beat(OP_READ, $urandom, 8'hFF);
    send_beat(OP_READ, $urandom, 8'd0);
    send_beat(OP_REMOVE, $urandom, 8'd0);
    send_beat(OP_REMOVE, value_pool[0], 8'd0);
    send_read_in_range();
    send_beat(OP_READ, $urandom, 8'hFF);
    send_beat(OP_CLEAR, $urandom, 8'd0);
  endtask

  // Hold the receiver off while beats keep coming, so the input stalls
  task automatic test_backpressure();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    rx_hold_req  = HOLD_CYCLES;
    for (int unsigned i = 0; i < 20; i++) begin
      if (i % 4 == 3) send_read_in_range();
      else send_beat(OP_APPEND, $urandom, 8'd0);
    end
  endtask

  // Mostly well-formed sequences from a small value pool, some noise
  task automatic test_random();
    int unsigned n_app;
    int unsigned n_ops;
    while (beats_sent < ITEM_TARGET) begin
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 85) begin
        refresh_pool();
        if ($urandom_range(0, 3) == 0)
          send_beat(OP_CLEAR, $urandom, IDX_W'($urandom_range(0, 255)));
        n_app = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 24) : $urandom_range(25, 80);
        for (int unsigned i = 0; i < n_app; i++)
          send_beat(OP_APPEND, pool_value(), IDX_W'($urandom_range(0, 255)));
        n_ops = $urandom_range(2, 10);
        for (int unsigned i = 0; i < n_ops; i++) begin
          case ($urandom_range(0, 5))
            0, 1: send_beat(OP_REMOVE, pool_value(), IDX_W'($urandom_range(0, 255)));
            2, 3: send_read_in_range();
            4: send_beat(OP_READ, $urandom, IDX_W'($urandom_range(0, 255)));
            default: send_beat(OP_APPEND, pool_value(), IDX_W'($urandom_range(0, 255)));
          endcase
        end
      end else begin
        n_ops = $urandom_range(1, 8);
        for (int unsigned i = 0; i < n_ops; i++)
          send_beat(op_e'($urandom_range(0, 3)), $urandom, IDX_W'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    mirror_count   = 0;
    mismatch_count = 0;
    beats_sent     = 0;
    op_beats       = '{default: 0};
    full_refusals  = 0;
    range_reads    = 0;
    removes_hit    = 0;
    peak_size      = 0;
    cycle_count    = 0;
    rx_hold_req    = 0;
    rx_hold_left   = 0;
    rx_stall_left  = 0;
    tx_gaps_on     = 1'b0;
    rx_stalls_on   = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_full_store();
    test_backpressure();
    test_random();

    // Drain, then allow for stray beats
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_resp_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("covered %0d beats: %0d appends, %0d removes, %0d reads, %0d clears",
             beats_sent, op_beats[OP_APPEND], op_beats[OP_REMOVE], op_beats[OP_READ],
             op_beats[OP_CLEAR]);
    $display("%0d removes with matches, %0d full refusals, %0d range misses, peak %0d entries",
             removes_hit, full_refusals, range_reads, peak_size);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mhrm_pkg.sv
rtl/mhrm_ram.sv
rtl/mhrm_cmp.sv
rtl/min_heap_remove_matching_core.sv
tb/testbench.sv
